[src/jams_pkg.sv]
// Package for the JSON array message splitter.
// Holds scanner phase codes, character codes, summary codes and the result record type.
// Depends on nothing.
package jams_pkg;

	localparam int ITEM_W = 4;
	localparam int OFF_W  = 16;

	localparam logic [2:0] PH_PRE   = 3'd0;
	localparam logic [2:0] PH_OPEN  = 3'd1;
	localparam logic [2:0] PH_ITEM  = 3'd2;
	localparam logic [2:0] PH_STR   = 3'd3;
	localparam logic [2:0] PH_ESC   = 3'd4;
	localparam logic [2:0] PH_COMMA = 3'd5;
	localparam logic [2:0] PH_CLOSE = 3'd6;
	localparam logic [2:0] PH_ERR   = 3'd7;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_TWO    = 8'h32;
	localparam logic [7:0] CH_THREE  = 8'h33;
	localparam logic [7:0] CH_FOUR   = 8'h34;
	localparam logic [7:0] CH_FIVE   = 8'h35;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_HDR  = 2'd2;

	localparam logic [1:0] KIND_CALL  = 2'd0;
	localparam logic [1:0] KIND_REPLY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;
	localparam logic [1:0] KIND_EVENT = 2'd3;

	typedef struct packed {
		logic              is_final;
		logic [ITEM_W-1:0] item_index;
		logic [OFF_W-1:0]  item_start;
		logic [OFF_W-1:0]  item_length;
		logic [1:0]        status;
		logic [ITEM_W-1:0] item_count;
		logic [1:0]        message_kind;
	} res_t;

endpackage

[src/json_array_message_splitter_core.sv]
// Top level of the JSON array message splitter: byte scanner and result register.
// Depends on jams_pkg.
//
// Usage: message bytes enter on the s_ channel, one byte per beat in s_tdata[7:0];
// a zero byte ends the message. Each item of the top-level array that completes
// leaves as one beat on the m_ channel with m_tuser low; the zero byte leaves a
// summary beat with m_tuser high (status, item count, message kind). Other bytes
// give no output beat.
// A result is presented on m_ in the cycle after the byte that causes it is
// accepted. Throughput: one byte per cycle, set by the single scanner state update
// that feeds the output register; s_tready stays high while the output register
// is empty or is being emptied in the same cycle.
// When the receiver stalls with a result pending, s_tready drops and the scanner
// holds its state until the result is taken.
// Reset clears the scanner to the start of a message and empties the output
// register. After every summary the scanner returns to that same state.
module json_array_message_splitter_core #(
	parameter int MAX_ITEMS   = 10,
	parameter int MAX_DEPTH   = 63,
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [3:0] item_index, [19:4] item_start, [35:20] item_length,
	                               // [37:36] status, [41:38] item_count, [43:42] message_kind,
	                               // [47:44] zero
	output logic        m_tuser    // [0] is_final
);
	import jams_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int OB = OFFSET_BITS;
	localparam logic [DW-1:0]     DEPTH_MAX = DW'(MAX_DEPTH);
	localparam logic [ITEM_W-1:0] ITEMS_MAX = ITEM_W'(MAX_ITEMS);
	localparam logic [OB-1:0]     POS_LAST  = {OB{1'b1}};

	logic [2:0]        phase_q, phase_d;
	logic [DW-1:0]     depth_q, depth_d;
	logic [OB-1:0]     pos_q, pos_d;
	logic [ITEM_W-1:0] items_q, items_d;
	logic [OB-1:0]     cs_q, cs_d;
	logic [OB-1:0]     lne_q, lne_d;
	logic [7:0]        fic_q, fic_d;
	logic              fis_q, fis_d;

	logic       in_beat;
	logic       res_valid;
	res_t       res;
	logic       out_valid_q;
	res_t       out_q;
	logic [7:0] c;
	logic       run_item;
	logic [OB-1:0] len;
	logic [1:0] fin_status;
	logic [1:0] fin_kind;

	assign c        = s_tdata[7:0];
	assign s_tready = !out_valid_q || m_tready;
	assign in_beat  = s_tvalid && s_tready;

	// Header check of the summary.
	always_comb begin
		fin_status = ST_SCAN;
		fin_kind   = KIND_CALL;
		if (phase_q == PH_CLOSE) begin
			fin_status = ST_HDR;
			if (items_q != '0 && fis_q) begin
				case (fic_q)
					CH_TWO: if (items_q == 4'd4 || items_q == 4'd5) begin
						fin_status = ST_OK;
						fin_kind   = KIND_CALL;
					end
					CH_THREE: if (items_q == 4'd3 || items_q == 4'd4) begin
						fin_status = ST_OK;
						fin_kind   = KIND_REPLY;
					end
					CH_FOUR: if (items_q == 4'd3 || items_q == 4'd4) begin
						fin_status = ST_OK;
						fin_kind   = KIND_ERROR;
					end
					CH_FIVE: if (items_q == 4'd3) begin
						fin_status = ST_OK;
						fin_kind   = KIND_EVENT;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		phase_d   = phase_q;
		depth_d   = depth_q;
		pos_d     = pos_q;
		items_d   = items_q;
		cs_d      = cs_q;
		lne_d     = lne_q;
		fic_d     = fic_q;
		fis_d     = fis_q;
		res_valid = 1'b0;
		res       = '0;
		run_item  = 1'b0;
		len       = '0;
		if (c == CH_NUL) begin
			res_valid        = 1'b1;
			res.is_final     = 1'b1;
			res.status       = fin_status;
			res.item_count   = items_q;
			res.message_kind = fin_kind;
			phase_d = PH_PRE;
			depth_d = '0;
			pos_d   = '0;
			items_d = '0;
			cs_d    = '0;
			lne_d   = '0;
			fic_d   = '0;
			fis_d   = 1'b0;
		end else if (phase_q == PH_ERR) begin
			phase_d = PH_ERR;
		end else if (pos_q == POS_LAST) begin
			phase_d = PH_ERR;
		end else begin
			pos_d = pos_q + 1'b1;
			case (phase_q)
				PH_PRE: begin
					if (c == CH_LBRACK) phase_d = PH_OPEN;
					else if (c != CH_SPACE) phase_d = PH_ERR;
				end
				PH_OPEN, PH_COMMA: begin
					if (phase_q == PH_OPEN && c == CH_RBRACK) begin
						phase_d = PH_CLOSE;
					end else if (c != CH_SPACE) begin
						// A new item begins on this byte.
						if (items_q >= ITEMS_MAX) begin
							phase_d = PH_ERR;
						end else begin
							cs_d     = pos_q;
							lne_d    = pos_q;
							if (items_q == '0) fic_d = c;
							depth_d  = '0;
							phase_d  = PH_ITEM;
							run_item = 1'b1;
						end
					end
				end
				PH_ITEM: run_item = 1'b1;
				PH_STR: begin
					lne_d = pos_q + 1'b1;
					if (c == CH_BSLASH) phase_d = PH_ESC;
					else if (c == CH_QUOTE) phase_d = PH_ITEM;
				end
				PH_ESC: begin
					if (c != CH_SPACE) lne_d = pos_q + 1'b1;
					phase_d = PH_STR;
				end
				PH_CLOSE: begin
					if (c != CH_SPACE) phase_d = PH_ERR;
				end
				default: phase_d = PH_ERR;
			endcase

			if (run_item) begin
				if (depth_d == '0 && (c == CH_COMMA || c == CH_RBRACK)) begin
					len = lne_d - cs_d;
					if (items_q == '0) fis_d = (len == OB'(1));
					res_valid       = 1'b1;
					res.item_index  = items_q;
					res.item_start  = OFF_W'(32'(cs_d));
					res.item_length = OFF_W'(32'(len));
					items_d = items_q + 1'b1;
					phase_d = (c == CH_RBRACK) ? PH_CLOSE : PH_COMMA;
				end else begin
					if (c != CH_SPACE) lne_d = pos_q + 1'b1;
					case (c)
						CH_LBRACE, CH_LBRACK: begin
							if (depth_d >= DEPTH_MAX) phase_d = PH_ERR;
							else depth_d = depth_d + 1'b1;
						end
						CH_RBRACE, CH_RBRACK: begin
							if (depth_d != '0) depth_d = depth_d - 1'b1;
							else phase_d = PH_ERR;
						end
						CH_QUOTE: phase_d = PH_STR;
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE;
			depth_q <= '0;
			pos_q   <= '0;
			items_q <= '0;
			cs_q    <= '0;
			lne_q   <= '0;
			fic_q   <= '0;
			fis_q   <= 1'b0;
		end else if (in_beat) begin
			phase_q <= phase_d;
			depth_q <= depth_d;
			pos_q   <= pos_d;
			items_q <= items_d;
			cs_q    <= cs_d;
			lne_q   <= lne_d;
			fic_q   <= fic_d;
			fis_q   <= fis_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= in_beat && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && res_valid) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.is_final;
	assign m_tdata  = {4'b0, out_q.message_kind, out_q.item_count, out_q.status,
	                   out_q.item_length, out_q.item_start, out_q.item_index};

	a_item_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[43:36] == 8'd0)
		else $error("item record carries summary fields");

	a_final_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[35:0] == 36'd0)
		else $error("summary carries item fields");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_MAX)
		else $error("nesting depth beyond limit");

	a_items_bound: assert property (@(posedge clk) disable iff (!arst_n)
		items_q <= ITEMS_MAX)
		else $error("item count beyond limit");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && c == CH_NUL |=> phase_q == PH_PRE && items_q == '0 && pos_q == '0)
		else $error("scanner not restarted after terminator");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

endmodule
